// ===== hdl/bounded_sequential_record_list_macros.svh =====
// assertion macros for the record list
`ifndef BOUNDED_SEQUENTIAL_RECORD_LIST_MACROS_SVH
`define BOUNDED_SEQUENTIAL_RECORD_LIST_MACROS_SVH

`ifndef ASSERT_OFF
`define BSRL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsrl: same-cycle check failed");
`define BSRL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsrl: next-cycle check failed");
`else
`define BSRL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BSRL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/bsrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsrl_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef logic [3:0] op_t;

  localparam op_t OP_APPEND       = 4'd0;
  localparam op_t OP_PREPEND      = 4'd1;
  localparam op_t OP_INSERT       = 4'd2;
  localparam op_t OP_READ         = 4'd3;
  localparam op_t OP_FIND         = 4'd4;
  localparam op_t OP_REMOVE       = 4'd5;
  localparam op_t OP_REMOVE_LAST  = 4'd6;
  localparam op_t OP_REMOVE_FIRST = 4'd7;
  localparam op_t OP_REMOVE_SWAP  = 4'd8;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [6:0]         position;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] found_key;
    logic [31:0]        found_payload;
    logic [6:0]         entry_count;
    logic               is_full_flag;
    logic               is_empty_flag;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_SHUP,
    ST_SHDN,
    ST_SWRD,
    ST_SWWR,
    ST_RDCAP,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/bsrl_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsrl_store #(
  parameter int CAPACITY     = bsrl_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bsrl_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic signed [31:0]               rd_key,
  output logic [PAYLOAD_BITS-1:0]          rd_pay,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  wire logic signed [31:0]          wr_key,
  input  wire logic [PAYLOAD_BITS-1:0]     wr_pay
);

  logic signed [31:0]      keys [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pays [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr] <= wr_key;
      pays[wr_addr] <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= keys[rd_addr];
      rd_pay <= pays[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsrl_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_sequential_record_list_macros.svh"

module bsrl_seq #(
  parameter int CAPACITY     = bsrl_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bsrl_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bsrl_pkg::cmd_t              cmd,
  output logic                             done,
  output bsrl_pkg::rsp_t                   rsp,
  output logic                             rd_en,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr,
  input  wire logic signed [31:0]          rd_key,
  input  wire logic [PAYLOAD_BITS-1:0]     rd_pay,
  output logic                             wr_en,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr,
  output logic signed [31:0]               wr_key,
  output logic [PAYLOAD_BITS-1:0]          wr_pay
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > 7) ? CW : 7;
  localparam int PMIN = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  bsrl_pkg::state_t state, state_next;

  logic [CW-1:0]           cnt, cnt_next;
  logic [CW-1:0]           idx, idx_next;
  logic [CW-1:0]           at, at_next;
  logic [CW-1:0]           chk, chk_next;
  logic                    chk_vld, chk_vld_next;
  logic                    pv, pv_next;
  logic [AW-1:0]           wa, wa_next;
  bsrl_pkg::op_t           op, op_next;
  logic signed [31:0]      key, key_next;
  logic [PAYLOAD_BITS-1:0] pay, pay_next;
  logic [6:0]              pos, pos_next;
  logic                    status, status_next;
  logic signed [31:0]      res_key, res_key_next;
  logic [PAYLOAD_BITS-1:0] res_pay, res_pay_next;

  logic [PAYLOAD_BITS-1:0] pay_in;
  logic [31:0]             res_pay32;
  logic                    cmp_lt, cmp_eq, match, found;
  logic                    cnt_full, cnt_zero;
  logic [PW-1:0]           pos_ext, cnt_ext, pos_m1;
  logic [CW-1:0]           idx_m1, cnt_m1;

  always_comb begin
    pay_in = '0;
    for (int b = 0; b < PMIN; b++) pay_in[b] = cmd.payload[b];
  end

  always_comb begin
    res_pay32 = '0;
    for (int b = 0; b < PMIN; b++) res_pay32[b] = res_pay[b];
  end

  // shared compare unit
  assign cmp_lt = rd_key < key;
  assign cmp_eq = rd_key == key;
  assign match  = (op == bsrl_pkg::OP_INSERT) ? !cmp_lt : cmp_eq;
  assign found  = chk_vld && match;

  assign cnt_full = cnt == CW'(CAPACITY);
  assign cnt_zero = cnt == '0;
  assign pos_ext  = PW'(pos);
  assign cnt_ext  = PW'(cnt);
  assign pos_m1   = pos_ext - PW'(1);
  assign idx_m1   = idx - CW'(1);
  assign cnt_m1   = cnt - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      idx     <= '0;
      chk_vld <= 1'b0;
      pv      <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      idx     <= idx_next;
      chk_vld <= chk_vld_next;
      pv      <= pv_next;
    end
  end

  always_ff @(posedge clk) begin
    at      <= at_next;
    chk     <= chk_next;
    wa      <= wa_next;
    op      <= op_next;
    key     <= key_next;
    pay     <= pay_next;
    pos     <= pos_next;
    status  <= status_next;
    res_key <= res_key_next;
    res_pay <= res_pay_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    at_next      = at;
    chk_next     = chk;
    chk_vld_next = chk_vld;
    pv_next      = pv;
    wa_next      = wa;
    op_next      = op;
    key_next     = key;
    pay_next     = pay;
    pos_next     = pos;
    status_next  = status;
    res_key_next = res_key;
    res_pay_next = res_pay;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_key       = key;
    wr_pay       = pay;
    done         = 1'b0;

    unique case (state)
      bsrl_pkg::ST_IDLE: begin
        if (start) begin
          op_next      = cmd.op;
          key_next     = cmd.key;
          pay_next     = pay_in;
          pos_next     = cmd.position;
          status_next  = bsrl_pkg::STATUS_OK;
          res_key_next = '0;
          res_pay_next = '0;
          state_next   = bsrl_pkg::ST_CMD;
        end
      end

      bsrl_pkg::ST_CMD: begin
        idx_next     = '0;
        chk_vld_next = 1'b0;
        pv_next      = 1'b0;
        state_next   = bsrl_pkg::ST_RESP;
        unique case (op) inside
          bsrl_pkg::OP_APPEND: begin
            if (cnt_full) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = cnt[AW-1:0];
              cnt_next = cnt + CW'(1);
            end
          end
          bsrl_pkg::OP_PREPEND: begin
            if (cnt_full) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              at_next    = '0;
              idx_next   = cnt;
              state_next = bsrl_pkg::ST_SHUP;
            end
          end
          bsrl_pkg::OP_INSERT: begin
            if (cnt_full) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              state_next = bsrl_pkg::ST_SCAN;
            end
          end
          bsrl_pkg::OP_READ: begin
            if (pos_ext == '0 || pos_ext > cnt_ext) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = pos_m1[AW-1:0];
              state_next = bsrl_pkg::ST_RDCAP;
            end
          end
          bsrl_pkg::OP_FIND: begin
            state_next = bsrl_pkg::ST_SCAN;
          end
          bsrl_pkg::OP_REMOVE, bsrl_pkg::OP_REMOVE_SWAP: begin
            if (cnt_zero) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              state_next = bsrl_pkg::ST_SCAN;
            end
          end
          bsrl_pkg::OP_REMOVE_LAST: begin
            if (cnt_zero) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              cnt_next = cnt_m1;
            end
          end
          bsrl_pkg::OP_REMOVE_FIRST: begin
            if (cnt_zero) begin
              status_next = bsrl_pkg::STATUS_ERR;
            end else begin
              idx_next   = CW'(1);
              state_next = bsrl_pkg::ST_SHDN;
            end
          end
          default: begin
            status_next = bsrl_pkg::STATUS_ERR;
          end
        endcase
      end

      // one read issued per cycle, compare on the word read the cycle before
      bsrl_pkg::ST_SCAN: begin
        if (found) begin
          at_next = chk;
          case (op)
            bsrl_pkg::OP_INSERT: begin
              idx_next   = cnt;
              state_next = bsrl_pkg::ST_SHUP;
            end
            bsrl_pkg::OP_REMOVE: begin
              idx_next   = chk + CW'(1);
              state_next = bsrl_pkg::ST_SHDN;
            end
            bsrl_pkg::OP_REMOVE_SWAP: begin
              state_next = bsrl_pkg::ST_SWRD;
            end
            default: begin
              res_key_next = rd_key;
              res_pay_next = rd_pay;
              state_next   = bsrl_pkg::ST_RESP;
            end
          endcase
        end else if (idx >= cnt && !chk_vld) begin
          at_next = cnt;
          case (op)
            bsrl_pkg::OP_INSERT: begin
              idx_next   = cnt;
              state_next = bsrl_pkg::ST_SHUP;
            end
            bsrl_pkg::OP_FIND: begin
              status_next = bsrl_pkg::STATUS_ERR;
              state_next  = bsrl_pkg::ST_RESP;
            end
            default: begin
              state_next = bsrl_pkg::ST_RESP;
            end
          endcase
        end else if (idx < cnt) begin
          rd_en        = 1'b1;
          rd_addr      = idx[AW-1:0];
          chk_next     = idx;
          chk_vld_next = 1'b1;
          idx_next     = idx + CW'(1);
        end else begin
          chk_vld_next = 1'b0;
        end
      end

      // move words up one slot, top first, then place the new word
      bsrl_pkg::ST_SHUP: begin
        if (pv) begin
          wr_en   = 1'b1;
          wr_addr = wa;
          wr_key  = rd_key;
          wr_pay  = rd_pay;
        end
        if (idx > at) begin
          rd_en    = 1'b1;
          rd_addr  = idx_m1[AW-1:0];
          wa_next  = idx[AW-1:0];
          pv_next  = 1'b1;
          idx_next = idx_m1;
        end else if (pv) begin
          pv_next = 1'b0;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = at[AW-1:0];
          cnt_next   = cnt + CW'(1);
          state_next = bsrl_pkg::ST_RESP;
        end
      end

      // move words down one slot into the hole
      bsrl_pkg::ST_SHDN: begin
        if (pv) begin
          wr_en   = 1'b1;
          wr_addr = wa;
          wr_key  = rd_key;
          wr_pay  = rd_pay;
        end
        if (idx < cnt) begin
          rd_en    = 1'b1;
          rd_addr  = idx[AW-1:0];
          wa_next  = idx_m1[AW-1:0];
          pv_next  = 1'b1;
          idx_next = idx + CW'(1);
        end else if (pv) begin
          pv_next = 1'b0;
        end else begin
          cnt_next   = cnt_m1;
          state_next = bsrl_pkg::ST_RESP;
        end
      end

      bsrl_pkg::ST_SWRD: begin
        rd_en      = 1'b1;
        rd_addr    = cnt_m1[AW-1:0];
        state_next = bsrl_pkg::ST_SWWR;
      end

      bsrl_pkg::ST_SWWR: begin
        wr_en      = 1'b1;
        wr_addr    = at[AW-1:0];
        wr_key     = rd_key;
        wr_pay     = rd_pay;
        cnt_next   = cnt_m1;
        state_next = bsrl_pkg::ST_RESP;
      end

      bsrl_pkg::ST_RDCAP: begin
        res_key_next = rd_key;
        res_pay_next = rd_pay;
        state_next   = bsrl_pkg::ST_RESP;
      end

      bsrl_pkg::ST_RESP: begin
        done       = 1'b1;
        state_next = bsrl_pkg::ST_IDLE;
      end

      default: begin
        state_next = bsrl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state != bsrl_pkg::ST_IDLE;

  assign rsp.status        = status;
  assign rsp.found_key     = res_key;
  assign rsp.found_payload = res_pay32;
  assign rsp.entry_count   = 7'(cnt);
  assign rsp.is_full_flag  = cnt_full;
  assign rsp.is_empty_flag = cnt_zero;

  `BSRL_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `BSRL_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `BSRL_ASSERT_IMP(a_wr_in_list, clk, rst, wr_en, CW'(wr_addr) <= cnt)
  `BSRL_ASSERT_NXT(a_idle_count, clk, rst, state == bsrl_pkg::ST_IDLE, $stable(cnt))
  `BSRL_ASSERT_IMP(a_cnt_cap, clk, rst, done, cnt <= CW'(CAPACITY))

endmodule

`default_nettype wire

// ===== hdl/bounded_sequential_record_list.sv =====
// Bounded list of records (signed key plus payload) held in slots 0..count-1.
// Command word: cmd (op, key, payload, position), accepted on a rising edge
// with start high and busy low. busy stays high until the result is shown.
// Result word: rsp (status, found_key, found_payload, entry_count, full and
// empty flags), valid for exactly one cycle while done is high; the receiver
// cannot stall it and must take it in that cycle.
// From the command state, append, remove last, an unused op and a rejected
// append, prepend, insert, read or remove go straight to the result state;
// read by position first captures the read word. Find and the removes by key
// scan the slots up to the match (all of them on a miss); remove by key with
// swap then reads the last slot and writes it into the hole. Prepend and
// sorted insert shift words up, remove first and remove by key with shift
// shift words down. busy falls in the cycle after done, so the next word is
// taken no earlier than the cycle after the result. The slot memory has a
// single read and a single write port: one slot is searched or moved per
// cycle. One command is in flight at a time.
// Reset empties the list at once (count cleared, no memory sweep); slot
// contents are left as they are and only slots below count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sequential_record_list #(
  parameter int CAPACITY     = bsrl_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bsrl_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire bsrl_pkg::cmd_t cmd,
  output logic                done,
  output bsrl_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic signed [31:0]      rd_key, wr_key;
  logic [PAYLOAD_BITS-1:0] rd_pay, wr_pay;

  bsrl_seq #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .rsp    (rsp),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_key (rd_key),
    .rd_pay (rd_pay),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_key (wr_key),
    .wr_pay (wr_pay)
  );

  bsrl_store #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_key (rd_key),
    .rd_pay (rd_pay),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_key (wr_key),
    .wr_pay (wr_pay)
  );

endmodule

`default_nettype wire

// ===== tb/bounded_sequential_record_list_tb.sv =====
`timescale 1ns / 1ps

module bounded_sequential_record_list_tb;

  localparam int CAP          = bsrl_pkg::CAPACITY_DEF;
  localparam int RAND_WORDS   = 1200;
  localparam int PHASE_WORDS  = 150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 80;

  localparam bsrl_pkg::op_t OP_SPARE_LO = 4'd9;
  localparam bsrl_pkg::op_t OP_SPARE_HI = 4'd15;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  localparam bsrl_pkg::rsp_t NO_RSP    = '0;
  localparam bsrl_pkg::rsp_t EMPTY_ERR =
    {bsrl_pkg::STATUS_ERR, 32'd0, 32'd0, 7'd0, 1'b0, 1'b1};
  localparam bsrl_pkg::rsp_t TWO_ERR   =
    {bsrl_pkg::STATUS_ERR, 32'd0, 32'd0, 7'd2, 1'b0, 1'b0};

  typedef struct packed {
    bsrl_pkg::cmd_t c;
    logic           typed;
    bsrl_pkg::rsp_t r;
  } dir_row_t;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  bsrl_pkg::cmd_t cmd   = '0;
  logic           busy;
  logic           done;
  bsrl_pkg::rsp_t rsp;

  logic signed [31:0] list_key [CAP];
  logic [31:0]        list_pay [CAP];
  int                 list_count  = 0;
  bsrl_pkg::rsp_t     pending_rsp [$];
  int                 err_count   = 0;
  int                 cycle_count = 0;
  int                 idle_pct    = 0;

  bounded_sequential_record_list i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int list_find(logic signed [31:0] k);
    int i;
    i = 0;
    while (i < list_count && list_key[i] != k) i++;
    return i;
  endfunction

  function automatic void list_close(int from);
    int i;
    for (i = from; i + 1 < list_count; i++) begin
      list_key[i] = list_key[i + 1];
      list_pay[i] = list_pay[i + 1];
    end
    list_count--;
  endfunction

  function automatic bsrl_pkg::rsp_t list_apply(bsrl_pkg::cmd_t c);
    bsrl_pkg::rsp_t r;
    int at;
    int i;
    logic hit;
    r = '0;
    at = 0;
    hit = 1'b0;
    r.status = bsrl_pkg::STATUS_OK;
    case (c.op) inside
      bsrl_pkg::OP_APPEND, bsrl_pkg::OP_PREPEND, bsrl_pkg::OP_INSERT: begin
        if (list_count >= CAP) begin
          r.status = bsrl_pkg::STATUS_ERR;
        end else begin
          if (c.op == bsrl_pkg::OP_APPEND) at = list_count;
          if (c.op == bsrl_pkg::OP_INSERT) begin
            while (at < list_count && list_key[at] < $signed(c.key)) at++;
          end
          for (i = list_count; i > at; i--) begin
            list_key[i] = list_key[i - 1];
            list_pay[i] = list_pay[i - 1];
          end
          list_key[at] = c.key;
          list_pay[at] = c.payload;
          list_count++;
        end
      end
      bsrl_pkg::OP_READ: begin
        if (c.position == 0 || c.position > list_count) begin
          r.status = bsrl_pkg::STATUS_ERR;
        end else begin
          at = c.position - 1;
          hit = 1'b1;
        end
      end
      bsrl_pkg::OP_FIND: begin
        at = list_find(c.key);
        if (at >= list_count) r.status = bsrl_pkg::STATUS_ERR;
        else hit = 1'b1;
      end
      bsrl_pkg::OP_REMOVE, bsrl_pkg::OP_REMOVE_LAST, bsrl_pkg::OP_REMOVE_FIRST,
      bsrl_pkg::OP_REMOVE_SWAP: begin
        if (list_count == 0) begin
          r.status = bsrl_pkg::STATUS_ERR;
        end else if (c.op == bsrl_pkg::OP_REMOVE_LAST) begin
          list_count--;
        end else if (c.op == bsrl_pkg::OP_REMOVE_FIRST) begin
          list_close(0);
        end else begin
          at = list_find(c.key);
          if (at < list_count) begin
            if (c.op == bsrl_pkg::OP_REMOVE) begin
              list_close(at);
            end else begin
              list_count--;
              list_key[at] = list_key[list_count];
              list_pay[at] = list_pay[list_count];
            end
          end
          at = 0;
        end
      end
      default: r.status = bsrl_pkg::STATUS_ERR;
    endcase
    if (hit) begin
      r.found_key = list_key[at];
      r.found_payload = list_pay[at];
    end
    r.entry_count = list_count[6:0];
    r.is_full_flag = (list_count == CAP);
    r.is_empty_flag = (list_count == 0);
    return r;
  endfunction

  function automatic string rsp_text(bsrl_pkg::rsp_t r);
    return $sformatf("status %0d key %h payload %h count %0d full %0d empty %0d",
                     r.status, r.found_key, r.found_payload, r.entry_count,
                     r.is_full_flag, r.is_empty_flag);
  endfunction

  task automatic flag_fail(input string what);
    err_count++;
    if (err_count <= 10) $display("%s", what);
  endtask

  task automatic send_word(input bsrl_pkg::cmd_t c, input logic typed,
                           input bsrl_pkg::rsp_t typed_rsp);
    bsrl_pkg::rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = list_apply(c);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  always @(posedge clk) begin
    bsrl_pkg::rsp_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_rsp.size() == 0) begin
        flag_fail($sformatf("unexpected result word: %s", rsp_text(rsp)));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.found_key !== want.found_key ||
            rsp.found_payload !== want.found_payload ||
            rsp.entry_count !== want.entry_count ||
            rsp.is_full_flag !== want.is_full_flag ||
            rsp.is_empty_flag !== want.is_empty_flag) begin
          flag_fail($sformatf("result mismatch: expected %s, got %s",
                              rsp_text(want), rsp_text(rsp)));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [26];
    bsrl_pkg::cmd_t c;
    logic grow;
    int n;
    int r;
    dir_tab = '{
      {{bsrl_pkg::OP_READ,         32'd0, 32'd0, 7'd1}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_REMOVE_LAST,  32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_REMOVE_FIRST, 32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_REMOVE,       32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_REMOVE_SWAP,  32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_FIND,         32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{OP_SPARE_LO,               32'd0, 32'd0, 7'd0}, TYPED, EMPTY_ERR},
      {{OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F}, TYPED, EMPTY_ERR},
      {{bsrl_pkg::OP_APPEND, KEY_MIN, 32'hFFFF_FFFF, 7'd0}, TYPED,
       {bsrl_pkg::STATUS_OK, 32'd0, 32'd0, 7'd1, 1'b0, 1'b0}},
      {{bsrl_pkg::OP_APPEND, KEY_MAX, 32'd0, 7'd0}, TYPED,
       {bsrl_pkg::STATUS_OK, 32'd0, 32'd0, 7'd2, 1'b0, 1'b0}},
      {{bsrl_pkg::OP_READ, 32'd0, 32'd0, 7'd1}, TYPED,
       {bsrl_pkg::STATUS_OK, KEY_MIN, 32'hFFFF_FFFF, 7'd2, 1'b0, 1'b0}},
      {{bsrl_pkg::OP_READ, 32'd0, 32'd0, 7'd2}, TYPED,
       {bsrl_pkg::STATUS_OK, KEY_MAX, 32'd0, 7'd2, 1'b0, 1'b0}},
      {{bsrl_pkg::OP_READ,         32'd0, 32'd0, 7'd0},  TYPED, TWO_ERR},
      {{bsrl_pkg::OP_READ,         32'd0, 32'd0, 7'd3},  TYPED, TWO_ERR},
      {{bsrl_pkg::OP_READ,         32'd0, 32'd0, 7'h7F}, TYPED, TWO_ERR},
      {{bsrl_pkg::OP_PREPEND, 32'd5, 32'hA5A5_A5A5, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_INSERT,  32'd0, 32'h5A5A_5A5A, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_APPEND,       32'd5, 32'd1, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_FIND,         32'd5, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_FIND,         32'd7, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_REMOVE,       32'd7, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_REMOVE,       32'd5, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_REMOVE_SWAP,  KEY_MIN, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_REMOVE_FIRST, 32'd0, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_REMOVE_LAST,  32'd0, 32'd0, 7'd0}, PREDICTED, NO_RSP},
      {{bsrl_pkg::OP_READ,         32'd0, 32'd0, 7'd1}, PREDICTED, NO_RSP}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

    // alternate fill and drain phases so that full and empty are both reached
    grow = 1'b1;
    for (n = 0; n < RAND_WORDS; n++) begin
      case ((n / PHASE_WORDS) % 4)
        1: idle_pct = 47;
        3: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      if (grow && list_count == CAP && $urandom_range(3) == 0) grow = 1'b0;
      else if (!grow && list_count == 0 && $urandom_range(3) == 0) grow = 1'b1;
      else if ($urandom_range(199) == 0) grow = !grow;

      r = $urandom_range(99);
      if (r < 3) begin
        c.op = bsrl_pkg::op_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else if (r < (grow ? 63 : 23)) begin
        c.op = bsrl_pkg::op_t'($urandom_range(bsrl_pkg::OP_INSERT,
                                              bsrl_pkg::OP_APPEND));
      end else if (r < (grow ? 73 : 38)) begin
        c.op = bsrl_pkg::OP_READ;
      end else if (r < (grow ? 83 : 53)) begin
        c.op = bsrl_pkg::OP_FIND;
      end else begin
        c.op = bsrl_pkg::op_t'($urandom_range(bsrl_pkg::OP_REMOVE_SWAP,
                                              bsrl_pkg::OP_REMOVE));
      end

      // keys from a narrow pool give hits and duplicates
      r = $urandom_range(3);
      if (r == 0) c.key = $urandom;
      else if (r == 1 && list_count > 0) c.key = list_key[$urandom_range(list_count - 1)];
      else c.key = $urandom_range(15) - 8;

      c.payload = $urandom;
      if ($urandom_range(9) < 7) c.position = 7'($urandom_range(list_count + 1));
      else c.position = 7'($urandom_range(127));

      send_word(c, PREDICTED, NO_RSP);
    end

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bsrl_pkg.sv
hdl/bsrl_store.sv
hdl/bsrl_seq.sv
hdl/bounded_sequential_record_list.sv
tb/bounded_sequential_record_list_tb.sv
